FILE: rtl/core/pru_pkg.sv
// Shared constants and types for the pixel replication upscaler.
// Holds size limits, field widths, register indexes, opcodes and result status codes.
// No dependencies.
`timescale 1ns / 1ps

package pru_pkg;

   // Size limits of the block.
   localparam int MAX_WIDTH = 1024;
   localparam int MAX_SCALE = 100;
   localparam int MAX_ROWS  = 4096;

   // Derived widths. A column index addresses the line store; the limit
   // fields are one bit wider so that they can hold the limit itself.
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int LIMW_W  = COL_W + 1;
   localparam int SCALE_W = $clog2(MAX_SCALE + 1);
   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int ROWS_W  = ROW_W + 1;

   // Fixed field widths.
   localparam int PIXEL_W        = 24;
   localparam int CSR_SCALE_W    = 7;
   localparam int CSR_WIDTH_W    = 11;
   localparam int CSR_ROWS_W     = 13;
   localparam int CSR_DATA_W     = 13;
   localparam int CSR_INDEX_W    = 2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_WIDTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT = 2'd2;

   // Request opcodes.
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_PULL = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_PIXEL   = 2'd0,
      STATUS_PAD     = 2'd1,
      STATUS_STORED  = 2'd2,
      STATUS_REFUSED = 2'd3
   } status_type;

endpackage

FILE: rtl/core/pixel_replication_upscaler_unit.sv
// Top level of the pixel replication upscaler: line store, control counters
// and the registered result stage. Depends on pru_pkg.
`timescale 1ns / 1ps

// The upscaler returns exactly one result word for each request word, in
// order. Push words (opcode 0) load one input row of 24-bit pixels into a
// 1024-entry line store; once row_width pixels are in, the block switches
// to emitting and pull words (opcode 1) read the row back, each pixel repeated
// scale times across and the whole row repeated scale times down, every
// output row followed by (scale*row_width) mod 4 zero pad words. rsp_line_end
// marks the last word of an output row and rsp_image_end the last word of
// the image after row_count input rows. A push while emitting or a pull
// while loading is answered with the refused status and changes nothing.
// Throughput is one word per cycle while results are drained: the single-port
// line store is read on the cycle a pull is accepted, and its registered
// read data forms the pixel of the result word. The result register decouples
// the two sides, so a new request is taken whenever the result register is
// empty or being drained. Configuration must be written through
// csr_we/csr_index/csr_wdata only while the block is idle; the block does
// not enforce this. Out-of-range values are clamped to the supported limits.
module pixel_replication_upscaler_unit
   import pru_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_opcode,
   input  logic [7:0]             req_blue,
   input  logic [7:0]             req_green,
   input  logic [7:0]             req_red,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [7:0]             rsp_out_blue,
   output logic [7:0]             rsp_out_green,
   output logic [7:0]             rsp_out_red,
   output logic                   rsp_line_end,
   output logic                   rsp_image_end
);

   // Configuration registers.
   logic [CSR_SCALE_W-1:0] scale_ff;
   logic [CSR_WIDTH_W-1:0] row_width_ff;
   logic [CSR_ROWS_W-1:0]  row_count_ff;

   // Control state.
   logic               emitting_ff, emitting_in;
   logic [COL_W-1:0]   load_col_ff, load_col_in;
   logic [COL_W-1:0]   read_col_ff, read_col_in;
   logic [SCALE_W-1:0] across_ff, across_in;
   logic [SCALE_W-1:0] down_ff, down_in;
   logic [1:0]         pad_ff, pad_in;
   logic [ROW_W-1:0]   input_row_ff, input_row_in;

   // Result register.
   logic               rsp_valid_ff;
   status_type         status_ff, status_in;
   logic               pix_sel_ff, pix_sel_in;
   logic               line_end_ff, line_end_in;
   logic               image_end_ff, image_end_in;

   // Line store and its registered read data.
   logic [PIXEL_W-1:0] line_store [MAX_WIDTH];
   logic [PIXEL_W-1:0] rd_data_ff;
   logic               mem_we, mem_re;
   logic [COL_W-1:0]   mem_addr;

   // Effective (clamped) configuration.
   logic [SCALE_W-1:0] eff_scale;
   logic [LIMW_W-1:0]  eff_width;
   logic [ROWS_W-1:0]  eff_rows;
   logic [3:0]         pad_prod;
   logic [1:0]         pad_amt;

   logic accept;
   logic finish_line;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Out-of-range register values are clamped: zero acts as one and values
   // above the supported maximum act as the maximum.
   always_comb begin
      if (scale_ff == '0) begin
         eff_scale = SCALE_W'(1);
      end else if (32'(scale_ff) > MAX_SCALE) begin
         eff_scale = SCALE_W'(MAX_SCALE);
      end else begin
         eff_scale = SCALE_W'(scale_ff);
      end

      if (row_width_ff == '0) begin
         eff_width = LIMW_W'(1);
      end else if (32'(row_width_ff) > MAX_WIDTH) begin
         eff_width = LIMW_W'(MAX_WIDTH);
      end else begin
         eff_width = LIMW_W'(row_width_ff);
      end

      if (row_count_ff == '0) begin
         eff_rows = ROWS_W'(1);
      end else if (32'(row_count_ff) > MAX_ROWS) begin
         eff_rows = ROWS_W'(MAX_ROWS);
      end else begin
         eff_rows = ROWS_W'(row_count_ff);
      end
   end

   // Only the two low bits of scale and width decide the pad count.
   assign pad_prod = {2'b00, eff_scale[1:0]} * {2'b00, eff_width[1:0]};
   assign pad_amt  = pad_prod[1:0];

   // Next-state logic for one accepted word.
   always_comb begin
      emitting_in  = emitting_ff;
      load_col_in  = load_col_ff;
      read_col_in  = read_col_ff;
      across_in    = across_ff;
      down_in      = down_ff;
      pad_in       = pad_ff;
      input_row_in = input_row_ff;
      status_in    = STATUS_REFUSED;
      pix_sel_in   = 1'b0;
      line_end_in  = 1'b0;
      image_end_in = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = read_col_ff;
      finish_line  = 1'b0;

      if (accept) begin
         case (req_opcode)
            OP_PUSH: begin
               if (!emitting_ff) begin
                  mem_we    = 1'b1;
                  mem_addr  = load_col_ff;
                  status_in = STATUS_STORED;
                  if ({1'b0, load_col_ff} + LIMW_W'(1) >= eff_width) begin
                     load_col_in = '0;
                     emitting_in = 1'b1;
                     read_col_in = '0;
                     across_in   = '0;
                     down_in     = '0;
                     pad_in      = '0;
                  end else begin
                     load_col_in = load_col_ff + COL_W'(1);
                  end
               end
            end
            OP_PULL: begin
               if (emitting_ff) begin
                  if (pad_ff != 2'd0) begin
                     status_in = STATUS_PAD;
                     pad_in    = pad_ff - 2'd1;
                     if (pad_ff == 2'd1) begin
                        finish_line = 1'b1;
                     end
                  end else begin
                     status_in  = STATUS_PIXEL;
                     pix_sel_in = 1'b1;
                     mem_re     = 1'b1;
                     if ({1'b0, across_ff} + (SCALE_W+1)'(1) >= {1'b0, eff_scale}) begin
                        across_in = '0;
                        if ({1'b0, read_col_ff} + LIMW_W'(1) >= eff_width) begin
                           read_col_in = '0;
                           if (pad_amt != 2'd0) begin
                              pad_in = pad_amt;
                           end else begin
                              finish_line = 1'b1;
                           end
                        end else begin
                           read_col_in = read_col_ff + COL_W'(1);
                        end
                     end else begin
                        across_in = across_ff + SCALE_W'(1);
                     end
                  end
               end
            end
            default: begin
               status_in = STATUS_REFUSED;
            end
         endcase

         // End of an output row: count the copy down and, after the last
         // copy, go back to loading and step the input row counter.
         if (finish_line) begin
            line_end_in = 1'b1;
            if ({1'b0, down_ff} + (SCALE_W+1)'(1) >= {1'b0, eff_scale}) begin
               down_in     = '0;
               emitting_in = 1'b0;
               load_col_in = '0;
               if ({1'b0, input_row_ff} + ROWS_W'(1) >= eff_rows) begin
                  image_end_in = 1'b1;
                  input_row_in = '0;
               end else begin
                  input_row_in = input_row_ff + ROW_W'(1);
               end
            end else begin
               down_in = down_ff + SCALE_W'(1);
            end
         end
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= CSR_SCALE_W'(1);
         row_width_ff <= CSR_WIDTH_W'(1);
         row_count_ff <= CSR_ROWS_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCALE:     scale_ff     <= csr_wdata[CSR_SCALE_W-1:0];
            CSR_ROW_WIDTH: row_width_ff <= csr_wdata[CSR_WIDTH_W-1:0];
            CSR_ROW_COUNT: row_count_ff <= csr_wdata[CSR_ROWS_W-1:0];
            default:       ;
         endcase
      end
   end

   // Control state and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         emitting_ff  <= 1'b0;
         load_col_ff  <= '0;
         read_col_ff  <= '0;
         across_ff    <= '0;
         down_ff      <= '0;
         pad_ff       <= '0;
         input_row_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         emitting_ff  <= emitting_in;
         load_col_ff  <= load_col_in;
         read_col_ff  <= read_col_in;
         across_ff    <= across_in;
         down_ff      <= down_in;
         pad_ff       <= pad_in;
         input_row_ff <= input_row_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload, loaded only when a word is accepted so that it holds
   // while the consumer stalls.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         pix_sel_ff   <= pix_sel_in;
         line_end_ff  <= line_end_in;
         image_end_ff <= image_end_in;
      end
   end

   // Line store. A write on one edge is visible to a read on the next, which
   // covers the first pull right after the last push of a row. The read data
   // register only changes on a pixel pull, so it holds during a stall.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_store[mem_addr] <= {req_red, req_green, req_blue};
      end
      if (mem_re) begin
         rd_data_ff <= line_store[mem_addr];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_blue  = pix_sel_ff ? rd_data_ff[7:0]   : 8'h00;
   assign rsp_out_green = pix_sel_ff ? rd_data_ff[15:8]  : 8'h00;
   assign rsp_out_red   = pix_sel_ff ? rd_data_ff[23:16] : 8'h00;
   assign rsp_line_end  = line_end_ff;
   assign rsp_image_end = image_end_ff;

endmodule
